@@ sv/ple_pkg.sv @@
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

   // Request field widths
   localparam int OP_W   = 2;
   localparam int POS_W  = 9;
   localparam int VAL_W  = 32;

   // Response field widths
   localparam int STS_W  = 2;
   localparam int CNT_W  = 9;

   // Stream data widths, rounded up to whole bytes
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef logic [OP_W-1:0]         op_type;
   typedef logic [POS_W-1:0]        pos_type;
   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [STS_W-1:0]        status_type;
   typedef logic [CNT_W-1:0]        count_type;

   // Operation codes
   localparam op_type OP_GET    = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_DELETE = 2'd2;

   // Status codes
   localparam status_type STS_OK     = 2'd0;
   localparam status_type STS_BADPOS = 2'd1;
   localparam status_type STS_FULL   = 2'd2;

endpackage

@@ sv/ple_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer, shift unit and response register.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit values held in one RAM.
// The req_ stream carries one request (get, insert before, delete at a
// 1-based position); every request yields exactly one response on rsp_
// with a status, the value read or removed, and the element count after it.
// Requests are handled one at a time; req_tready is high only while the
// sequencer is idle. After acceptance, a request passes a range check;
// a bad position, full list or unknown code then goes to the response.
// A get reads the element; an insert moves the elements at and above
// the position up one place, one element moved per cycle, then writes
// the value; a delete reads the element, then moves the ones above it
// down, one element moved per cycle. The next request is taken in the
// cycle after the response is loaded.
// The move rate is set by the RAM's single read and single write port; one
// cursor with one incrementer/decrementer and compare walks the shift.
// The response sits in an output register, so the next request is taken
// while a finished response still waits for rsp_tready. If the sink stalls
// with the register full, a further result holds the sequencer until the
// register drains. Reset (synchronous) empties the list and drops any
// pending response; RAM contents are not cleared.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // op[1:0], position[10:2], value[42:11], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[1:0], read_value[33:2], count[42:34], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
   localparam logic [CW-1:0] DEPTH_W = CW'(DEPTH);

   // Sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_GET     = 3'd2;
   localparam logic [2:0] S_INS_SH  = 3'd3;
   localparam logic [2:0] S_INS_PUT = 3'd4;
   localparam logic [2:0] S_DEL_GET = 3'd5;
   localparam logic [2:0] S_DEL_SH  = 3'd6;
   localparam logic [2:0] S_FINISH  = 3'd7;

   logic [2:0]       state_ff, state_in;
   op_type           op_ff, op_in;
   pos_type          pos_ff, pos_in;
   value_type        val_ff, val_in;
   logic [LW-1:0]    len_ff, len_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [AW-1:0]    wa_ff, wa_in;
   status_type       res_sts_ff, res_sts_in;
   value_type        res_val_ff, res_val_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [VAL_W-1:0] ram_wdata;
   logic             ram_re;
   logic [AW-1:0]    ram_raddr;
   logic [VAL_W-1:0] ram_rdata;

   logic [CW-1:0]    pos_w;
   logic [CW-1:0]    len_w;
   logic [AW-1:0]    p0;
   logic [LW-1:0]    nxt;
   logic             more;
   logic             load_rsp;
   count_type        count_out;

   // Element store
   ple_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Widened position and length for range checks
   assign pos_w = CW'(pos_ff);
   assign len_w = CW'(len_ff);
   assign p0    = AW'(pos_ff - POS_W'(1));

   // Shared cursor unit: step down while inserting, up while deleting
   assign nxt  = (state_ff == S_INS_SH) ? (LW'(cur_ff) - LW'(1)) : (LW'(cur_ff) + LW'(1));
   assign more = (state_ff == S_INS_SH) ? (cur_ff > p0) : (nxt < len_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign load_rsp   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);
   assign count_out  = len_w[CNT_W-1:0];

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      len_in     = len_ff;
      cur_in     = cur_ff;
      wa_in      = wa_ff;
      res_sts_in = res_sts_ff;
      res_val_in = res_val_ff;
      ram_we     = 1'b0;
      ram_waddr  = wa_ff;
      ram_wdata  = ram_rdata;
      ram_re     = 1'b0;
      ram_raddr  = p0;
      case (state_ff)
         S_IDLE: begin
            // Capture the request
            if (req_tvalid) begin
               op_in    = req_tdata[OP_W-1:0];
               pos_in   = req_tdata[OP_W +: POS_W];
               val_in   = req_tdata[OP_W+POS_W +: VAL_W];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // Range check, then start the read or the shift
            res_sts_in = STS_BADPOS;
            res_val_in = '0;
            state_in   = S_FINISH;
            case (op_ff)
               OP_GET: begin
                  if (pos_w != '0 && pos_w <= len_w) begin
                     ram_re   = 1'b1;
                     state_in = S_GET;
                  end
               end
               OP_INSERT: begin
                  if (pos_w != '0 && pos_w <= len_w + CW'(1)) begin
                     if (len_w == DEPTH_W) begin
                        res_sts_in = STS_FULL;
                     end else if (len_w >= pos_w) begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(len_ff - LW'(1));
                        cur_in    = AW'(len_ff - LW'(1));
                        wa_in     = AW'(len_ff);
                        state_in  = S_INS_SH;
                     end else begin
                        state_in = S_INS_PUT;
                     end
                  end
               end
               OP_DELETE: begin
                  if (pos_w != '0 && pos_w <= len_w) begin
                     ram_re   = 1'b1;
                     cur_in   = p0;
                     state_in = S_DEL_GET;
                  end
               end
               default: begin
                  res_sts_in = STS_BADPOS;
               end
            endcase
         end
         S_GET: begin
            res_sts_in = STS_OK;
            res_val_in = ram_rdata;
            state_in   = S_FINISH;
         end
         S_INS_SH: begin
            // Move one element up, read the next one below
            ram_we = 1'b1;
            wa_in  = cur_ff;
            if (more) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(nxt);
               cur_in    = AW'(nxt);
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            ram_we     = 1'b1;
            ram_waddr  = p0;
            ram_wdata  = val_ff;
            len_in     = len_ff + LW'(1);
            res_sts_in = STS_OK;
            res_val_in = '0;
            state_in   = S_FINISH;
         end
         S_DEL_GET: begin
            // Return the removed element, start closing the gap
            res_sts_in = STS_OK;
            res_val_in = ram_rdata;
            if (more) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(nxt);
               wa_in     = cur_ff;
               cur_in    = AW'(nxt);
               state_in  = S_DEL_SH;
            end else begin
               len_in   = len_ff - LW'(1);
               state_in = S_FINISH;
            end
         end
         S_DEL_SH: begin
            // Move one element down, read the next one above
            ram_we = 1'b1;
            wa_in  = cur_ff;
            if (more) begin
               ram_re    = 1'b1;
               ram_raddr = AW'(nxt);
               cur_in    = AW'(nxt);
            end else begin
               len_in   = len_ff - LW'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hold until the response register is free
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_TDATA_W'({count_out, res_val_ff, res_sts_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      cur_ff      <= cur_in;
      wa_ff       <= wa_in;
      res_sts_ff  <= res_sts_in;
      res_val_ff  <= res_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Length never exceeds the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_w <= DEPTH_W)
      else $error("list length above depth");

   // One request at a time: no new request right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // The store is never written while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff != S_IDLE))
      else $error("store written while idle");

   // A full status is only reported with a full list
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && res_sts_ff == STS_FULL) |-> (len_w == DEPTH_W))
      else $error("full status with room left");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the positional list engine, with a shadow list and random traffic.
`timescale 1ns / 1ps
module tb;
   import ple_pkg::*;

   localparam int LIST_DEPTH = 256;
   // Unused operation code; the engine answers it with a bad position status
   localparam op_type OP_NONE = 2'd3;

   typedef struct {
      status_type status;
      value_type  read_value;
      count_type  count;
   } reply_type;

   // Shadow copy of the list; predicts each reply and checks what comes back
   class list_shadow_type;
      value_type cells[LIST_DEPTH];
      int        length;
      reply_type expected_replies[$];
      int        failures;
      int        reported;

      function new();
         length   = 0;
         failures = 0;
         reported = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void note_request(op_type op, pos_type pos, value_type val);
         reply_type r;
         int        p;
         p            = pos;
         r.status     = STS_BADPOS;
         r.read_value = '0;
         case (op)
            OP_GET: begin
               if (p >= 1 && p <= length) begin
                  r.read_value = cells[p-1];
                  r.status     = STS_OK;
               end
            end
            OP_INSERT: begin
               if (p >= 1 && p <= length + 1) begin
                  if (length >= LIST_DEPTH) begin
                     r.status = STS_FULL;
                  end else begin
                     for (int k = length; k > p - 1; k--) cells[k] = cells[k-1];
                     cells[p-1] = val;
                     length++;
                     r.status = STS_OK;
                  end
               end
            end
            OP_DELETE: begin
               if (p >= 1 && p <= length) begin
                  r.read_value = cells[p-1];
                  for (int k = p - 1; k + 1 < length; k++) cells[k] = cells[k+1];
                  length--;
                  r.status = STS_OK;
               end
            end
            default: ;
         endcase
         r.count = count_type'(length);
         expected_replies.push_back(r);
      endfunction

      function void check_reply(logic [RSP_TDATA_W-1:0] data);
         reply_type  want;
         status_type got_status;
         value_type  got_value;
         count_type  got_count;
         got_status = data[1:0];
         got_value  = data[33:2];
         got_count  = data[42:34];
         if (expected_replies.size() == 0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display("unexpected reply: status %0d value %0d count %0d",
                        got_status, got_value, got_count);
            end
            return;
         end
         want = expected_replies.pop_front();
         if (got_status != want.status || got_value != want.read_value ||
             got_count != want.count || data[RSP_TDATA_W-1:43] != '0) begin
            failures++;
            if (reported < 10) begin
               reported++;
               $display({"reply mismatch: status exp %0d got %0d, value exp %0d got %0d,",
                         " count exp %0d got %0d, fill %h"},
                        want.status, got_status, want.read_value, got_value,
                        want.count, got_count, data[RSP_TDATA_W-1:43]);
            end
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   list_shadow_type shadow = new();
   int  tx_idle_pct = 0;
   int  rx_stall_pct = 0;
   int  sent_count = 0;
   logic hold_on = 1'b0;

   // Random walk state: grow toward full, dwell there, shrink toward empty, dwell there
   bit  growing = 1'b1;
   int  dwell = 0;

   positional_list_engine #(.DEPTH(LIST_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Drive the sink ready; drop it for the whole hold stretch
   always @(posedge clock) begin
      rsp_tready <= !hold_on && ($urandom_range(99) >= rx_stall_pct);
   end

   // Check every reply taken by the sink
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_reply(rsp_tdata);
   end

   // Hold off the sink for a long stretch while requests keep coming
   initial begin
      wait (sent_count >= 150);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (1000) @(posedge clock);
      hold_on <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic send_request(op_type op, pos_type pos, value_type val);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tdata  <= {5'b0, val, pos, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      shadow.note_request(op, pos, val);
      sent_count++;
   endtask

   // Stop sending and wait until every reply has come back
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (shadow.pending() != 0);
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(19))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic pos_type pick_position(int upper);
      if (upper < 1) return 9'd1;
      case ($urandom_range(3))
         0:       return 9'd1;
         1:       return pos_type'(upper);
         default: return pos_type'($urandom_range(1, upper));
      endcase
   endfunction

   function automatic void next_random(output op_type op, output pos_type pos,
                                       output value_type val);
      int len;
      int roll;
      len  = shadow.length;
      roll = $urandom_range(99);
      // Flip direction after dwelling a while at either end
      if (growing && len == LIST_DEPTH) begin
         dwell++;
         if (dwell >= 30) begin
            growing = 1'b0;
            dwell   = 0;
         end
      end else if (!growing && len == 0) begin
         dwell++;
         if (dwell >= 10) begin
            growing = 1'b1;
            dwell   = 0;
         end
      end
      val = pick_value();
      if (roll < 4) begin
         op  = op_type'($urandom_range(3));
         pos = pos_type'($urandom_range(511));
      end else if (roll < 9) begin
         op  = op_type'($urandom_range(3));
         pos = $urandom_range(1) ? 9'd0
               : pos_type'(len + 1 + ((op == OP_INSERT) ? 1 : 0));
      end else begin
         roll = $urandom_range(99);
         if (roll < 20) op = OP_GET;
         else if (roll < 85) op = growing ? OP_INSERT : OP_DELETE;
         else op = growing ? OP_DELETE : OP_INSERT;
         pos = pick_position((op == OP_INSERT) ? len + 1 : len);
      end
   endfunction

   initial begin
      op_type    op;
      pos_type   pos;
      value_type val;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, ends of the list, bad positions, unused code
      send_request(OP_GET,    9'd1,   '0);
      send_request(OP_DELETE, 9'd1,   '0);
      send_request(OP_INSERT, 9'd0,   32'h1234_5678);
      send_request(OP_INSERT, 9'd2,   32'h1234_5678);
      send_request(OP_INSERT, 9'd1,   32'h7fff_ffff);
      send_request(OP_INSERT, 9'd1,   32'h8000_0000);
      send_request(OP_INSERT, 9'd3,   '1);
      send_request(OP_INSERT, 9'd2,   '0);
      send_request(OP_INSERT, 9'd511, 32'h5a5a_a5a5);
      send_request(OP_GET,    9'd1,   '1);
      send_request(OP_GET,    9'd2,   '0);
      send_request(OP_GET,    9'd3,   '0);
      send_request(OP_GET,    9'd4,   '0);
      send_request(OP_GET,    9'd5,   '0);
      send_request(OP_GET,    9'd0,   '0);
      send_request(OP_NONE,   9'd1,   32'hdead_beef);
      send_request(OP_GET,    9'd511, '0);
      send_request(OP_DELETE, 9'd4,   '0);
      send_request(OP_DELETE, 9'd1,   '0);
      send_request(OP_INSERT, 9'd2,   32'h0f0f_f0f0);
      send_request(OP_DELETE, 9'd2,   '0);
      send_request(OP_DELETE, 9'd0,   '0);
      send_request(OP_DELETE, 9'd3,   '0);
      send_request(OP_DELETE, 9'd511, '0);

      // Random phases with different idle patterns; drain between phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 64; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 64; end
            default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
         endcase
         repeat (400) begin
            next_random(op, pos, val);
            send_request(op, pos, val);
         end
         drain_replies();
      end

      // Let any stray reply show up before the verdict
      repeat (300) @(posedge clock);
      if (shadow.failures == 0 && shadow.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
